FILE: src/rc3_pkg.sv
`default_nettype none

package rc3_pkg;

  // Frame limits and window geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int TAPS       = 3;
  localparam int WIN_N      = TAPS * TAPS;

  // Pixel and coefficient formats
  localparam int CHAN_N = 3;
  localparam int CHAN_W = 8;
  localparam int PIX_W  = CHAN_N * CHAN_W;
  localparam int COEF_W = 16;
  localparam int KROW_W = TAPS * COEF_W;

  // Register and result widths
  localparam int DIM_W     = 11;
  localparam int SUM_W     = 28;
  localparam int PROD_W    = CHAN_W + 1 + COEF_W;
  localparam int ROW_SUM_W = PROD_W + 2;
  localparam int TOT_W     = ROW_SUM_W + 2;

  // Position and count widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int SPAN_W = ($clog2(MAX_WIDTH + 2) > $clog2(MAX_HEIGHT + 2)) ?
                          $clog2(MAX_WIDTH + 2) : $clog2(MAX_HEIGHT + 2);
  localparam int ARITH_W = ((SPAN_W > DIM_W) ? SPAN_W : DIM_W) + 1;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W = 3;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]  RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  RESET_HEIGHT = DIM_W'(480);
  localparam logic [KROW_W-1:0] RESET_KROW_EDGE   = '0;
  localparam logic [KROW_W-1:0] RESET_KROW_CENTER = KROW_W'(65536);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]                 pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0]      win_t;
  typedef logic [TAPS-1:0][KROW_W-1:0]      kernel_t;
  typedef logic signed [SUM_W-1:0]          sum_t;

  // Request leaving the line stage for the multiply-accumulate pipeline
  typedef struct packed {
    logic valid;
    logic conv;
    logic last;
    pix_t px;
  } meta_t;

  // One result
  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
    logic last;
  } res_t;

endpackage

`default_nettype wire

FILE: src/rc3_ram.sv
`default_nettype none

module rc3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data (old data on a collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/rc3_line.sv
`default_nettype none

module rc3_line import rc3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  op_t              op,
  input  pix_t             px_in,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  output logic             emit,
  output meta_t            meta,
  output win_t             win
);

  // Position and pending count
  logic [COL_W-1:0]   col, col_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [PEND_W-1:0]  pending, pending_next;

  logic [ARITH_W-1:0] w_eff, h_eff, c_x, r_x, n_x, p0, c1, r1, orow, ocol;
  logic               at_start, f_emit, p_emit, inner;
  logic [COL_W-1:0]   ra_up, ra_lo;

  // Stage 1 registers (memory data arrives)
  logic             s1_valid, s1_emit, s1_inner, s1_last, s1_flush_up;
  op_t              s1_op;
  pix_t             s1_px;
  logic [COL_W-1:0] s1_col, s1_ra_up, s1_ra_lo;

  pix_t             up_rd, lo_rd, up_f, lo_f;
  logic             wr_en;

  // Forwarding of the write made in the previous cycle
  logic             fw_valid;
  logic [COL_W-1:0] fw_addr;
  pix_t             fw_up, fw_lo;

  win_t             window;
  meta_t            meta_d;

  // Clamp the frame size
  always_comb begin
    if (frame_width == '0) begin
      w_eff = ARITH_W'(1);
    end else if (ARITH_W'(frame_width) > ARITH_W'(MAX_WIDTH)) begin
      w_eff = ARITH_W'(MAX_WIDTH);
    end else begin
      w_eff = ARITH_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = ARITH_W'(1);
    end else if (ARITH_W'(frame_height) > ARITH_W'(MAX_HEIGHT)) begin
      h_eff = ARITH_W'(MAX_HEIGHT);
    end else begin
      h_eff = ARITH_W'(frame_height);
    end
  end

  // Decide the result and the next position for the request at the input
  always_comb begin
    c_x      = ARITH_W'(col);
    r_x      = ARITH_W'(row);
    n_x      = ARITH_W'(pending);
    at_start = (col == '0) && (row == '0);
    f_emit   = at_start && (pending != '0);
    p0       = at_start ? '0 : n_x;
    p_emit   = p0 >= (w_eff + ARITH_W'(1));
    c1       = c_x + ARITH_W'(1);
    r1       = r_x + ARITH_W'(1);

    if (c_x >= ARITH_W'(1)) begin
      orow = r_x - ARITH_W'(1);
      ocol = c_x - ARITH_W'(1);
    end else begin
      orow = r_x - ARITH_W'(2);
      ocol = w_eff - ARITH_W'(1);
    end
    inner = (w_eff >= ARITH_W'(TAPS)) && (h_eff >= ARITH_W'(TAPS)) &&
            (r_x >= ARITH_W'(1)) && ((c_x >= ARITH_W'(1)) || (r_x >= ARITH_W'(2))) &&
            (orow >= ARITH_W'(1)) && ((orow + ARITH_W'(2)) <= h_eff) &&
            (ocol >= ARITH_W'(1)) && ((ocol + ARITH_W'(2)) <= w_eff);

    col_next     = col;
    row_next     = row;
    pending_next = pending;
    if (op == OP_FLUSH) begin
      emit = f_emit;
      if (f_emit) begin
        pending_next = PEND_W'(n_x - ARITH_W'(1));
      end
      ra_up = COL_W'(w_eff - ARITH_W'(1));
      ra_lo = COL_W'(w_eff - n_x);
    end else begin
      emit = p_emit;
      pending_next = p_emit ? PEND_W'(w_eff + ARITH_W'(1)) : PEND_W'(p0 + ARITH_W'(1));
      if (c1 >= w_eff) begin
        col_next = '0;
        row_next = (r1 >= h_eff) ? '0 : ROW_W'(r1);
      end else begin
        col_next = COL_W'(c1);
      end
      ra_up = col;
      ra_lo = col;
    end
  end

  // Advance position on each pixel request and update the pending count on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      pending <= '0;
    end else if (take) begin
      col     <= col_next;
      row     <= row_next;
      pending <= pending_next;
    end
  end

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op       <= op;
      s1_emit     <= emit;
      s1_inner    <= inner;
      s1_last     <= (op == OP_FLUSH) && (n_x == ARITH_W'(1));
      s1_flush_up <= n_x > w_eff;
      s1_px       <= px_in;
      s1_col      <= col;
      s1_ra_up    <= ra_up;
      s1_ra_lo    <= ra_lo;
    end
  end

  // Line stores: row two back and row one back
  rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (lo_f),
    .rd_addr (ra_up),
    .rd_data (up_rd)
  );

  rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (s1_px),
    .rd_addr (ra_lo),
    .rd_data (lo_rd)
  );

  // Forward the write that collided with this read
  always_comb begin
    up_f  = (fw_valid && (fw_addr == s1_ra_up)) ? fw_up : up_rd;
    lo_f  = (fw_valid && (fw_addr == s1_ra_lo)) ? fw_lo : lo_rd;
    wr_en = s1_valid && (s1_op == OP_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fw_addr <= s1_col;
    fw_up   <= lo_f;
    fw_lo   <= s1_px;
  end

  // Shift the window left and load the new right column
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS - 1; j++) begin
          window[i*TAPS + j] <= window[i*TAPS + j + 1];
        end
      end
      window[TAPS-1]      <= up_f;
      window[2*TAPS-1]    <= lo_f;
      window[TAPS*TAPS-1] <= s1_px;
    end
  end

  // Build the request for the arithmetic pipeline
  always_comb begin
    meta_d.valid = s1_valid && s1_emit;
    meta_d.conv  = (s1_op == OP_PIXEL) && s1_inner;
    meta_d.last  = s1_last;
    if (s1_op == OP_FLUSH) begin
      meta_d.px = s1_flush_up ? up_f : lo_f;
    end else begin
      meta_d.px = window[2*TAPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta <= '0;
    end else begin
      meta <= meta_d;
    end
  end

  assign win = window;

endmodule

`default_nettype wire

FILE: src/rc3_mac.sv
`default_nettype none

module rc3_mac import rc3_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  meta_t   meta,
  input  win_t    win,
  input  kernel_t kernel,
  output logic    push,
  output res_t    res
);

  logic signed [PROD_W-1:0]    prod [CHAN_N][WIN_N];
  logic signed [ROW_SUM_W-1:0] rsum [CHAN_N][TAPS];
  logic signed [TOT_W-1:0]     tot  [CHAN_N];
  sum_t                        chan_res [CHAN_N];
  meta_t                       meta_a, meta_b;

  // Multiply each window tap by its coefficient
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHAN_N; ch++) begin
      for (int k = 0; k < WIN_N; k++) begin
        prod[ch][k] <= $signed({1'b0, win[k][ch*CHAN_W +: CHAN_W]}) *
                       $signed(kernel[k/TAPS][(k%TAPS)*COEF_W +: COEF_W]);
      end
    end
  end

  // Sum each kernel row
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHAN_N; ch++) begin
      for (int i = 0; i < TAPS; i++) begin
        rsum[ch][i] <= ROW_SUM_W'(prod[ch][i*TAPS]) +
                       ROW_SUM_W'(prod[ch][i*TAPS + 1]) +
                       ROW_SUM_W'(prod[ch][i*TAPS + 2]);
      end
    end
  end

  // Add the rows and pick the border value
  always_comb begin
    for (int ch = 0; ch < CHAN_N; ch++) begin
      tot[ch] = '0;
      for (int i = 0; i < TAPS; i++) begin
        tot[ch] = tot[ch] + TOT_W'(rsum[ch][i]);
      end
      if (meta_b.conv) begin
        chan_res[ch] = tot[ch][SUM_W-1:0];
      end else begin
        chan_res[ch] = sum_t'(meta_b.px[ch*CHAN_W +: CHAN_W]);
      end
    end
  end

  // Carry the request alongside the arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_a <= '0;
      meta_b <= '0;
      push   <= 1'b0;
    end else begin
      meta_a <= meta;
      meta_b <= meta_a;
      push   <= meta_b.valid;
    end
  end

  always_ff @(posedge clk) begin
    res.red   <= chan_res[0];
    res.green <= chan_res[1];
    res.blue  <= chan_res[2];
    res.last  <= meta_b.last;
  end

endmodule

`default_nettype wire

FILE: src/rc3_fifo.sv
`default_nettype none

module rc3_fifo import rc3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic reserve,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic out_valid,
  output res_t out_data,
  output logic full
);

  res_t                  q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count, count_next;
  logic [FIFO_CNT_W-1:0] held, held_next;

  // Count stored entries and entries promised to requests in flight
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + FIFO_CNT_W'(1);
    end else if (!push && pop) begin
      count_next = count - FIFO_CNT_W'(1);
    end
    held_next = held;
    if (reserve && !pop) begin
      held_next = held + FIFO_CNT_W'(1);
    end else if (!reserve && pop) begin
      held_next = held - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      held   <= '0;
    end else begin
      count <= count_next;
      held  <= held_next;
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  assign out_valid = count != '0;
  assign out_data  = q[rd_ptr];
  assign full      = held >= FIFO_CNT_W'(FIFO_DEPTH);

endmodule

`default_nettype wire

FILE: src/rgb_convolution_3x3.sv
// Channel   Signals                                       Direction
// input     in_valid, in_stall, opcode, red/green/blue_in  request in, stall out
// output    out_valid, out_stall, red/green/blue_out,      request out, stall in
//           frame_last
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      write in, always ready
//
// One request per cycle is taken while in_stall is low; each result is registered before it leaves.
// The two line stores are single-write, single-read memories; back-to-back
// requests to the same column are served by forwarding the write in flight.
// An 8-entry output queue is reserved at acceptance, so in_stall rises only
// once 8 results are queued or in flight behind a stalled output.
// Reset clears position, window and queue and restores 640x480 with the
// identity kernel; line stores are not cleared.
`default_nettype none

module rgb_convolution_3x3 import rc3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [CHAN_W-1:0]     red_in,
  input  logic [CHAN_W-1:0]     green_in,
  input  logic [CHAN_W-1:0]     blue_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [SUM_W-1:0] red_out,
  output logic signed [SUM_W-1:0] green_out,
  output logic signed [SUM_W-1:0] blue_out,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KROW_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] frame_width, frame_height;
  kernel_t          kernel;

  logic  take, emit, full, push, pop;
  meta_t meta;
  win_t  win;
  res_t  res, out_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      kernel[0]    <= RESET_KROW_EDGE;
      kernel[1]    <= RESET_KROW_CENTER;
      kernel[2]    <= RESET_KROW_EDGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height <= cfg_data[DIM_W-1:0];
        REG_KERNEL_TOP:    kernel[0]    <= cfg_data;
        REG_KERNEL_MIDDLE: kernel[1]    <= cfg_data;
        REG_KERNEL_BOTTOM: kernel[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept while the output queue has room for every result in flight
  assign in_stall = full;
  assign take     = in_valid && !full;
  assign pop      = out_valid && !out_stall;

  rc3_line u_line (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .op           (op_t'(opcode)),
    .px_in        ({blue_in, green_in, red_in}),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .emit         (emit),
    .meta         (meta),
    .win          (win)
  );

  rc3_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .meta   (meta),
    .win    (win),
    .kernel (kernel),
    .push   (push),
    .res    (res)
  );

  rc3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .reserve   (take && emit),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

  assign red_out    = out_data.red;
  assign green_out  = out_data.green;
  assign blue_out   = out_data.blue;
  assign frame_last = out_data.last;

endmodule

`default_nettype wire

FILE: bench/rc3_checker.sv
`timescale 1ns / 1ps

module rc3_checker import rc3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  op_t               opcode,
  input  logic [CHAN_W-1:0] red_in,
  input  logic [CHAN_W-1:0] green_in,
  input  logic [CHAN_W-1:0] blue_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  sum_t              red_out,
  input  sum_t              green_out,
  input  sum_t              blue_out,
  input  logic              frame_last,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  cfg_reg_t          cfg_index,
  input  logic [KROW_W-1:0] cfg_data,
  output int                fail_count,
  output int                expected_left,
  output int                results_checked
);

  localparam int PRINT_MAX = 100;

  // Shadow of the block: registers, line stores, window and frame position
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [KROW_W-1:0] kernel_rows [TAPS];
  pix_t              upper_line [MAX_WIDTH];
  pix_t              lower_line [MAX_WIDTH];
  pix_t              win [TAPS][TAPS];
  int                col_pos;
  int                row_pos;
  int                owed;
  res_t              pixels_due [$];

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= PRINT_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic sum_t widen(input logic [CHAN_W-1:0] c);
    return sum_t'(c);
  endfunction

  function automatic res_t passed_through(input pix_t px, input logic last);
    res_t r;
    r.red   = widen(px[CHAN_W-1:0]);
    r.green = widen(px[2*CHAN_W-1:CHAN_W]);
    r.blue  = widen(px[3*CHAN_W-1:2*CHAN_W]);
    r.last  = last;
    return r;
  endfunction

  // Weighted sum of one color channel over the window
  function automatic sum_t window_sum(input int ch);
    logic signed [COEF_W-1:0] k;
    int acc;
    int i;
    int j;
    acc = 0;
    for (i = 0; i < TAPS; i++) begin
      for (j = 0; j < TAPS; j++) begin
        k = kernel_rows[i][COEF_W*j +: COEF_W];
        acc += int'(win[i][j][CHAN_W*ch +: CHAN_W]) * int'(k);
      end
    end
    return sum_t'(acc);
  endfunction

  // Advance the frame by one request and queue the result it releases
  task automatic convolve_request(input op_t op, input pix_t px);
    int w;
    int h;
    int c;
    int i;
    int orow;
    int ocol;
    logic inner;
    res_t r;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);

    // drain one owed pixel, only between frames
    if (op == OP_FLUSH) begin
      if (row_pos == 0 && col_pos == 0 && owed > 0) begin
        if (owed > w) r = passed_through(upper_line[w-1], owed == 1);
        else r = passed_through(lower_line[w-owed], owed == 1);
        owed--;
        pixels_due.push_back(r);
      end
      return;
    end

    // a new frame drops whatever the last one still owed
    if (row_pos == 0 && col_pos == 0) owed = 0;

    // shift the window and rotate the line stores
    c = col_pos % MAX_WIDTH;
    for (i = 0; i < TAPS; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = lower_line[c];
    win[2][2] = px;
    upper_line[c] = lower_line[c];
    lower_line[c] = px;

    if (owed >= w + 1) begin
      owed = w + 1;
      if (col_pos >= 1) begin
        orow = row_pos - 1;
        ocol = col_pos - 1;
      end else begin
        orow = row_pos - 2;
        ocol = w - 1;
      end
      inner = w >= 3 && h >= 3 && row_pos >= 1 && (col_pos >= 1 || row_pos >= 2) &&
              orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
      if (inner) begin
        r.red   = window_sum(0);
        r.green = window_sum(1);
        r.blue  = window_sum(2);
        r.last  = 1'b0;
      end else begin
        r = passed_through(win[1][1], 1'b0);
      end
      pixels_due.push_back(r);
    end else begin
      owed++;
    end

    // step the raster position
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    int i;
    int j;
    if (rst) begin
      width_reg      = RESET_WIDTH;
      height_reg     = RESET_HEIGHT;
      kernel_rows[0] = RESET_KROW_EDGE;
      kernel_rows[1] = RESET_KROW_CENTER;
      kernel_rows[2] = RESET_KROW_EDGE;
      for (i = 0; i < TAPS; i++) begin
        for (j = 0; j < TAPS; j++) win[i][j] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      owed    = 0;
      pixels_due.delete();
      fail_count      = 0;
      results_checked = 0;
      expected_left <= 0;
    end else begin
      // take register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   width_reg = cfg_data[DIM_W-1:0];
          REG_FRAME_HEIGHT:  height_reg = cfg_data[DIM_W-1:0];
          REG_KERNEL_TOP:    kernel_rows[0] = cfg_data;
          REG_KERNEL_MIDDLE: kernel_rows[1] = cfg_data;
          REG_KERNEL_BOTTOM: kernel_rows[2] = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) convolve_request(opcode, {blue_in, green_in, red_in});

      // compare each delivered result with the oldest one owed
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          report($sformatf("result %0d with nothing expected: %0d %0d %0d last %b",
                           results_checked, red_out, green_out, blue_out, frame_last));
        end else begin
          want = pixels_due.pop_front();
          if (red_out !== want.red)
            report($sformatf("result %0d red got %0d want %0d",
                             results_checked, red_out, want.red));
          if (green_out !== want.green)
            report($sformatf("result %0d green got %0d want %0d",
                             results_checked, green_out, want.green));
          if (blue_out !== want.blue)
            report($sformatf("result %0d blue got %0d want %0d",
                             results_checked, blue_out, want.blue));
          if (frame_last !== want.last)
            report($sformatf("result %0d frame_last got %b want %b",
                             results_checked, frame_last, want.last));
        end
        results_checked++;
      end

      expected_left <= pixels_due.size();
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rc3_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int GAP_MAX     = 11;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 16;
  localparam int RAND_ITEMS  = 500;

  localparam logic [COEF_W-1:0] COEF_PICKS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  op_t               opcode = OP_PIXEL;
  logic [CHAN_W-1:0] red_in = '0;
  logic [CHAN_W-1:0] green_in = '0;
  logic [CHAN_W-1:0] blue_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sum_t              red_out;
  sum_t              green_out;
  sum_t              blue_out;
  logic              frame_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_reg_t          cfg_index = REG_FRAME_WIDTH;
  logic [KROW_W-1:0] cfg_data = '0;

  int   fail_count;
  int   expected_left;
  int   results_checked;
  int   cycle_count = 0;
  int   pixel_count = 0;
  int   flush_count = 0;
  int   settings_count = 0;
  int   work_items = 0;
  int   eff_w = 1;
  int   eff_h = 1;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  logic long_hold = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  rgb_convolution_3x3 DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rc3_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .expected_left(expected_left),
    .results_checked(results_checked)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, expected_left);
      $display("FAIL rgb_convolution_3x3");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each result
  initial begin : result_side
    int hold;
    bit long_done;
    long_done = 1'b0;
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (long_hold && !long_done) begin
        hold = HOLD_CYCLES;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic int eff_dim(input int v, input int hi);
    return (v == 0) ? 1 : (v > hi) ? hi : v;
  endfunction

  // Results a complete frame leaves for the flush requests
  function automatic int owed_after_frame();
    return (eff_h >= 2) ? eff_w + 1 : eff_w;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t px;
    int ch;
    px = pix_t'($urandom);
    for (ch = 0; ch < CHAN_N; ch++) begin
      if ($urandom_range(0, 7) == 0)
        px[CHAN_W*ch +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  function automatic logic [KROW_W-1:0] rand_krow();
    logic [KROW_W-1:0] k;
    int j;
    k = KROW_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: ;
      1: for (j = 0; j < TAPS; j++) k[COEF_W*j +: COEF_W] = COEF_PICKS[$urandom_range(0, 3)];
      default: for (j = 0; j < TAPS; j++) k[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(0, 8) - 4);
    endcase
    return k;
  endfunction

  // Offer one request after a random gap, hold it until taken
  task automatic offer(input op_t op, input pix_t px);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    red_in   <= px[CHAN_W-1:0];
    green_in <= px[2*CHAN_W-1:CHAN_W];
    blue_in  <= px[3*CHAN_W-1:2*CHAN_W];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain(input int k);
    repeat (k) offer(OP_FLUSH, rand_pixel());
    flush_count += k;
    work_items  += k;
  endtask

  // One full frame of pixels, with a stray flush now and then inside it
  task automatic run_frame(input int hold_at);
    int n;
    for (n = 0; n < eff_w * eff_h; n++) begin
      if (n > 0 && $urandom_range(0, 15) == 0) begin
        offer(OP_FLUSH, rand_pixel());
        flush_count++;
      end
      if (n == hold_at) long_hold <= 1'b1;
      offer(OP_PIXEL, rand_pixel());
      pixel_count++;
      work_items++;
    end
  endtask

  // Drop valid and wait until every owed result is out and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_left == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [KROW_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input int w, input int h, input logic [KROW_W-1:0] k_top,
                              input logic [KROW_W-1:0] k_mid, input logic [KROW_W-1:0] k_bot);
    wait_idle();
    set_reg(REG_FRAME_WIDTH, KROW_W'(w));
    set_reg(REG_FRAME_HEIGHT, KROW_W'(h));
    set_reg(REG_KERNEL_TOP, k_top);
    set_reg(REG_KERNEL_MIDDLE, k_mid);
    set_reg(REG_KERNEL_BOTTOM, k_bot);
    eff_w = eff_dim(w, MAX_WIDTH);
    eff_h = eff_dim(h, MAX_HEIGHT);
    settings_count++;
  endtask

  initial begin : stimulus
    int n;
    int f;
    int frames;
    int w;
    int h;
    int mark;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // most negative sum: every coefficient at its minimum over a white frame
    load_setting(3, 3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    offer(OP_FLUSH, '0);
    flush_count++;
    for (n = 0; n < 9; n++) begin
      if (n == 4) begin
        offer(OP_FLUSH, '1);
        flush_count++;
      end
      offer(OP_PIXEL, '1);
      pixel_count++;
    end
    drain(4);

    // most positive sum on red, zero on green, mixed blue
    load_setting(3, 3, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    for (n = 0; n < 9; n++) begin
      offer(OP_PIXEL, {(n % 2) ? 8'hFF : 8'h00, 8'h00, 8'hFF});
      pixel_count++;
    end
    drain(4);

    // wider frame, with a long output hold-off once results flow
    load_setting(32, 4, rand_krow(), rand_krow(), rand_krow());
    run_frame(60);
    drain(owed_after_frame());

    // random small frames, one to three per setting
    mark = work_items;
    while (work_items - mark < RAND_ITEMS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin w = 0; h = $urandom_range(0, 6); end
        1: begin w = $urandom_range(1, 2); h = $urandom_range(1, 8); end
        2: begin w = $urandom_range(3, 12); h = 0; end
        3: begin w = $urandom_range(13, 32); h = 3; end
        4: begin w = $urandom_range(3, 12); h = $urandom_range(1, 2); end
        default: begin w = $urandom_range(3, 12); h = $urandom_range(3, 8); end
      endcase
      load_setting(w, h, rand_krow(), rand_krow(), rand_krow());
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        run_frame(-1);
        // leave results owed now and then so the next frame drops them
        if (f == frames - 1 || $urandom_range(0, 3) != 0) drain(owed_after_frame());
        else drain($urandom_range(0, owed_after_frame() - 1));
      end
      // flushes with nothing owed
      n = $urandom_range(0, 2);
      repeat (n) offer(OP_FLUSH, rand_pixel());
      flush_count += n;
    end

    wait_idle();
    $display("Ran %0d pixels and %0d flush requests over %0d frame and kernel settings,",
             pixel_count, flush_count, settings_count);
    $display("frame sizes from 1x1 up to 32 wide and 8 tall; %0d results compared.",
             results_checked);
    if (fail_count == 0 && expected_left == 0) begin
      $display("PASS rgb_convolution_3x3");
    end else begin
      $display("FAIL rgb_convolution_3x3");
    end
    $finish;
  end

endmodule
